@@ design/tmse_pkg.sv @@
// ----------------------------------------------------------------------------
// tmse_pkg: shared types and constants of the Turing machine step engine
// Sizes of the rule table, state table and tape, plus operation, status and
// state kind codes, and the write request structs between the stores.
// ----------------------------------------------------------------------------
package tmse_pkg;

  // Table and tape sizes
  localparam int TAPE_CELLS       = 1024;
  localparam int TRANSITION_SLOTS = 256;
  localparam int STATE_COUNT      = 256;

  localparam int TAPE_AW  = $clog2(TAPE_CELLS);
  localparam int TAPE_CW  = $clog2(TAPE_CELLS + 1);
  localparam int SLOT_AW  = $clog2(TRANSITION_SLOTS);
  localparam int SLOT_CW  = $clog2(TRANSITION_SLOTS + 1);
  localparam int STATE_AW = $clog2(STATE_COUNT);

  // Fixed field widths
  localparam int SYM_W   = 8;
  localparam int STATE_W = 8;
  localparam int STEP_W  = 16;

  localparam logic [STEP_W-1:0] MAX_STEPS_RESET = 16'd1000;

  // Configuration register indexes
  localparam logic CFG_START_STATE = 1'b0;
  localparam logic CFG_MAX_STEPS   = 1'b1;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_KIND    = 3'd1,
    OP_TAPE    = 3'd2,
    OP_RESTART = 3'd3,
    OP_STEP    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_REJECT  = 3'd2,
    ST_QUIT    = 3'd3,
    ST_NOTRANS = 3'd4,
    ST_OFFTAPE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SYM,
    S_SEARCH,
    S_APPLY,
    S_DONE
  } fsm_e;

  // One transition rule
  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   read_symbol;
    logic [STATE_W-1:0] next_state;
    logic [SYM_W-1:0]   write_symbol;
    logic               move_right;
  } rule_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    rule_t              rule;
  } rule_wr_t;

  typedef struct packed {
    logic                en;
    logic [STATE_AW-1:0] addr;
    logic [1:0]          kind;
  } kind_wr_t;

  typedef struct packed {
    logic               en;
    logic [TAPE_AW-1:0] addr;
    logic [SYM_W-1:0]   data;
  } tape_wr_t;

endpackage

@@ design/tmse_rule_store.sv @@
// ----------------------------------------------------------------------------
// tmse_rule_store: transition rule memory
// One write port and one registered read port; a valid flag per slot that
// reset clears, so an unwritten slot never matches.
// ----------------------------------------------------------------------------
module tmse_rule_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmse_pkg::rule_wr_t            wr_i,
  input  logic                          rd_en_i,
  input  logic [tmse_pkg::SLOT_AW-1:0]  rd_addr_i,
  output tmse_pkg::rule_t               rd_rule_o,
  output logic                          rd_valid_o
);

  tmse_pkg::rule_t                        mem [tmse_pkg::TRANSITION_SLOTS];
  logic [tmse_pkg::TRANSITION_SLOTS-1:0]  valid_q;
  tmse_pkg::rule_t                        rd_rule_q;
  logic                                   rd_valid_q;

  // Mark slots as loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Write and read the rule array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.rule;
    end
    if (rd_en_i) begin
      rd_rule_q  <= mem[rd_addr_i];
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_rule_o  = rd_rule_q;
  assign rd_valid_o = rd_valid_q;

endmodule

@@ design/tmse_kind_store.sv @@
// ----------------------------------------------------------------------------
// tmse_kind_store: state kind memory
// Kind per state with a valid flag per entry; unwritten entries and states
// beyond the table read as kind none. Registered read.
// ----------------------------------------------------------------------------
module tmse_kind_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmse_pkg::kind_wr_t            wr_i,
  input  logic                          rd_en_i,
  input  logic [tmse_pkg::STATE_W-1:0]  rd_state_i,
  output logic [1:0]                    rd_kind_o
);

  logic [1:0]                        mem [tmse_pkg::STATE_COUNT];
  logic [tmse_pkg::STATE_COUNT-1:0]  valid_q;
  logic [1:0]                        rd_kind_q;
  logic                              rd_valid_q;
  logic [tmse_pkg::STATE_AW-1:0]     rd_addr;
  logic                              rd_in_range;

  assign rd_addr     = tmse_pkg::STATE_AW'(rd_state_i);
  assign rd_in_range = int'(rd_state_i) < tmse_pkg::STATE_COUNT;

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Write and read the kind array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.kind;
    end
    if (rd_en_i) begin
      rd_kind_q  <= mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr] & rd_in_range;
    end
  end

  assign rd_kind_o = rd_valid_q ? rd_kind_q : tmse_pkg::KIND_NONE;

endmodule

@@ design/tmse_tape_store.sv @@
// ----------------------------------------------------------------------------
// tmse_tape_store: tape memory
// One write port and one registered read port. After reset a sweep writes
// zero to every cell, one cell per cycle, while busy_o is high.
// ----------------------------------------------------------------------------
module tmse_tape_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmse_pkg::tape_wr_t            wr_i,
  input  logic                          rd_en_i,
  input  logic [tmse_pkg::TAPE_AW-1:0]  rd_addr_i,
  output logic [tmse_pkg::SYM_W-1:0]    rd_data_o,
  output logic                          busy_o
);

  logic [tmse_pkg::SYM_W-1:0]    mem [tmse_pkg::TAPE_CELLS];
  logic [tmse_pkg::TAPE_CW-1:0]  clr_cnt_q;
  logic                          clearing;
  logic [tmse_pkg::SYM_W-1:0]    rd_data_q;

  assign clearing = clr_cnt_q != tmse_pkg::TAPE_CW'(tmse_pkg::TAPE_CELLS);

  // Advance the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Write (sweep first) and read the tape
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_cnt_q[tmse_pkg::TAPE_AW-1:0]] <= '0;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clearing;

endmodule

@@ design/turing_machine_step_engine.sv @@
// ----------------------------------------------------------------------------
// turing_machine_step_engine: single-tape Turing machine step engine
// Sequencer plus rule, state kind and tape stores; one result per item.
// ----------------------------------------------------------------------------
// After reset the tape is cleared and in_ready_o rises in the cycle after the
// sweep ends; configuration writes are taken meanwhile. Load, kind, tape
// write, restart and ignored codes go from idle straight to the result. A
// step reads the tape symbol, then takes its time from the rule search: one
// shared comparator checks one slot per cycle in slot order, and the first
// match is applied; a step with no matching rule ends after the last slot,
// and a step on a halted run or at the step limit goes straight to the result.
// The result sits in an output register, so the next item is taken while the
// previous result waits.
module turing_machine_step_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  // input items
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [2:0]   operation_i,
  input  logic [7:0]   slot_i,
  input  logic [7:0]   from_state_i,
  input  logic [7:0]   read_symbol_i,
  input  logic [7:0]   next_state_i,
  input  logic [7:0]   write_symbol_i,
  input  logic         move_right_i,
  input  logic [7:0]   state_id_i,
  input  logic [1:0]   state_kind_i,
  input  logic [9:0]   tape_address_i,
  input  logic [7:0]   tape_symbol_i,
  // result items
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   current_state_o,
  output logic [2:0]   status_o,
  output logic [15:0]  step_count_o,
  output logic [9:0]   head_position_o,
  output logic [7:0]   symbol_written_o
);

  localparam int TAPE_AW = tmse_pkg::TAPE_AW;
  localparam int SLOT_AW = tmse_pkg::SLOT_AW;
  localparam int SLOT_CW = tmse_pkg::SLOT_CW;
  localparam int SYM_W   = tmse_pkg::SYM_W;
  localparam int STATE_W = tmse_pkg::STATE_W;
  localparam int STEP_W  = tmse_pkg::STEP_W;

  tmse_pkg::fsm_e     fsm_q, fsm_d;
  logic [STATE_W-1:0] cur_state_q, cur_state_d;
  logic [TAPE_AW-1:0] head_q, head_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  tmse_pkg::status_e  status_q, status_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [SLOT_CW-1:0] idx_q, idx_d;
  logic               pend_q, pend_d;
  tmse_pkg::rule_t    hit_q, hit_d;
  logic [SYM_W-1:0]   written_q, written_d;
  logic [STATE_W-1:0] start_q;
  logic [STEP_W-1:0]  max_q;

  logic               out_valid_q, out_valid_d;
  logic [STATE_W-1:0] out_state_q;
  tmse_pkg::status_e  out_status_q;
  logic [STEP_W-1:0]  out_steps_q;
  logic [TAPE_AW-1:0] out_head_q;
  logic [SYM_W-1:0]   out_wr_q;
  logic               out_load;

  tmse_pkg::rule_wr_t rule_wr;
  tmse_pkg::kind_wr_t kind_wr;
  tmse_pkg::tape_wr_t tape_wr;
  logic               rule_rd_en;
  tmse_pkg::rule_t    rule_rd;
  logic               rule_rd_valid;
  logic               kind_rd_en;
  logic [1:0]         kind_rd;
  logic               tape_rd_en;
  logic [SYM_W-1:0]   tape_rd;
  logic               tape_busy;

  logic               in_fire;
  logic               issue;
  logic               match;
  logic [STEP_W-1:0]  steps_inc;
  tmse_pkg::status_e  apply_status;

  assign in_ready_o = fsm_q == tmse_pkg::S_IDLE;
  assign in_fire    = in_valid_i & in_ready_o;

  // Stores
  tmse_rule_store u_rule_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (rule_wr),
    .rd_en_i    (rule_rd_en),
    .rd_addr_i  (idx_q[SLOT_AW-1:0]),
    .rd_rule_o  (rule_rd),
    .rd_valid_o (rule_rd_valid)
  );

  tmse_kind_store u_kind_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (kind_wr),
    .rd_en_i    (kind_rd_en),
    .rd_state_i (rule_rd.next_state),
    .rd_kind_o  (kind_rd)
  );

  tmse_tape_store u_tape_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tape_wr),
    .rd_en_i   (tape_rd_en),
    .rd_addr_i (head_q),
    .rd_data_o (tape_rd),
    .busy_o    (tape_busy)
  );

  // Shared slot comparator
  assign issue = idx_q != SLOT_CW'(tmse_pkg::TRANSITION_SLOTS);
  assign match = pend_q & rule_rd_valid
               & (rule_rd.from_state == cur_state_q)
               & (rule_rd.read_symbol == sym_q);

  assign steps_inc = steps_q + 1'b1;

  // Outcome of an applied rule, and the head reset on restart
  always_comb begin
    apply_status = tmse_pkg::ST_RUN;
    head_d       = head_q;
    priority if (kind_rd == tmse_pkg::KIND_ACCEPT) begin
      apply_status = tmse_pkg::ST_ACCEPT;
    end else if (kind_rd == tmse_pkg::KIND_REJECT) begin
      apply_status = tmse_pkg::ST_REJECT;
    end else if (hit_q.move_right) begin
      if (head_q == TAPE_AW'(tmse_pkg::TAPE_CELLS - 1)) begin
        apply_status = tmse_pkg::ST_OFFTAPE;
      end else begin
        head_d = head_q + 1'b1;
      end
    end else begin
      if (head_q == '0) begin
        apply_status = tmse_pkg::ST_OFFTAPE;
      end else begin
        head_d = head_q - 1'b1;
      end
    end
    if (apply_status == tmse_pkg::ST_RUN && steps_inc >= max_q) begin
      apply_status = tmse_pkg::ST_QUIT;
    end
    if (fsm_q != tmse_pkg::S_APPLY) begin
      head_d = head_q;
      if (fsm_q == tmse_pkg::S_IDLE && in_fire && operation_i == tmse_pkg::OP_RESTART) begin
        head_d = '0;
      end
    end
  end

  // Sequencer: next state and store controls
  always_comb begin
    fsm_d       = fsm_q;
    cur_state_d = cur_state_q;
    steps_d     = steps_q;
    status_d    = status_q;
    sym_d       = sym_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    written_d   = written_q;
    rule_wr     = '0;
    kind_wr     = '0;
    tape_wr     = '0;
    rule_rd_en  = 1'b0;
    kind_rd_en  = 1'b0;
    tape_rd_en  = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (fsm_q)
      tmse_pkg::S_CLEAR: begin
        if (!tape_busy) begin
          fsm_d = tmse_pkg::S_IDLE;
        end
      end
      tmse_pkg::S_IDLE: begin
        if (in_fire) begin
          written_d = '0;
          fsm_d     = tmse_pkg::S_DONE;
          case (operation_i)
            tmse_pkg::OP_LOAD: begin
              rule_wr.en   = int'(slot_i) < tmse_pkg::TRANSITION_SLOTS;
              rule_wr.addr = SLOT_AW'(slot_i);
              rule_wr.rule = '{from_state:   from_state_i,
                               read_symbol:  read_symbol_i,
                               next_state:   next_state_i,
                               write_symbol: write_symbol_i,
                               move_right:   move_right_i};
            end
            tmse_pkg::OP_KIND: begin
              kind_wr.en   = int'(state_id_i) < tmse_pkg::STATE_COUNT;
              kind_wr.addr = tmse_pkg::STATE_AW'(state_id_i);
              kind_wr.kind = state_kind_i;
            end
            tmse_pkg::OP_TAPE: begin
              tape_wr.en   = int'(tape_address_i) < tmse_pkg::TAPE_CELLS;
              tape_wr.addr = TAPE_AW'(tape_address_i);
              tape_wr.data = tape_symbol_i;
            end
            tmse_pkg::OP_RESTART: begin
              cur_state_d = start_q;
              steps_d     = '0;
              status_d    = tmse_pkg::ST_RUN;
            end
            tmse_pkg::OP_STEP: begin
              if (status_q == tmse_pkg::ST_RUN) begin
                if (steps_q >= max_q) begin
                  status_d = tmse_pkg::ST_QUIT;
                end else begin
                  tape_rd_en = 1'b1;
                  fsm_d      = tmse_pkg::S_SYM;
                end
              end
            end
            default: begin
              // unknown codes report the current values
            end
          endcase
        end
      end
      tmse_pkg::S_SYM: begin
        sym_d  = tape_rd;
        idx_d  = '0;
        pend_d = 1'b0;
        fsm_d  = tmse_pkg::S_SEARCH;
      end
      tmse_pkg::S_SEARCH: begin
        priority if (match) begin
          hit_d      = rule_rd;
          kind_rd_en = 1'b1;
          pend_d     = 1'b0;
          fsm_d      = tmse_pkg::S_APPLY;
        end else if (!pend_q && !issue) begin
          status_d = tmse_pkg::ST_NOTRANS;
          fsm_d    = tmse_pkg::S_DONE;
        end else begin
          rule_rd_en = issue;
          pend_d     = issue;
          if (issue) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      tmse_pkg::S_APPLY: begin
        tape_wr.en   = 1'b1;
        tape_wr.addr = head_q;
        tape_wr.data = hit_q.write_symbol;
        cur_state_d  = hit_q.next_state;
        steps_d      = steps_inc;
        status_d     = apply_status;
        written_d    = hit_q.write_symbol;
        fsm_d        = tmse_pkg::S_DONE;
      end
      tmse_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          fsm_d       = tmse_pkg::S_IDLE;
        end
      end
      default: begin
        fsm_d = tmse_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= tmse_pkg::S_CLEAR;
      cur_state_q <= '0;
      head_q      <= '0;
      steps_q     <= '0;
      status_q    <= tmse_pkg::ST_RUN;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      cur_state_q <= cur_state_d;
      head_q      <= head_d;
      steps_q     <= steps_d;
      status_q    <= status_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      max_q   <= tmse_pkg::MAX_STEPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmse_pkg::CFG_START_STATE: start_q <= cfg_data_i[STATE_W-1:0];
        tmse_pkg::CFG_MAX_STEPS:   max_q   <= cfg_data_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    hit_q     <= hit_d;
    written_q <= written_d;
    if (out_load) begin
      out_state_q  <= cur_state_q;
      out_status_q <= status_q;
      out_steps_q  <= steps_q;
      out_head_q   <= head_q;
      out_wr_q     <= written_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign current_state_o  = out_state_q;
  assign status_o         = out_status_q;
  assign step_count_o     = out_steps_q;
  assign head_position_o  = 10'(out_head_q);
  assign symbol_written_o = out_wr_q;

`ifndef ASSERT_OFF
  // No item is taken while the tape is being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tape_busy |-> !in_ready_o)
    else $error("item accepted during tape clear");

  // A rule is applied only right after a match in the search
  a_apply_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == tmse_pkg::S_APPLY |-> $past(fsm_q) == tmse_pkg::S_SEARCH)
    else $error("apply without search");

  // A step that found no rule reports a written symbol of zero
  a_notrans_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_q == tmse_pkg::ST_NOTRANS && fsm_q == tmse_pkg::S_DONE
     && $past(fsm_q) == tmse_pkg::S_SEARCH) |=> symbol_written_o == '0)
    else $error("symbol reported without a matching rule");

  // Machine state holds while idle with no item
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == tmse_pkg::S_IDLE && !in_valid_i) |=>
      $stable(steps_q) && $stable(head_q) && $stable(cur_state_q))
    else $error("machine state changed while idle");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Turing machine step engine
// A queue-fed driver offers items with random gaps; a clocked monitor takes
// results under random back-pressure and checks every field against a local
// model of the machine: rule slots, state kinds, tape, head and step limit.
// ----------------------------------------------------------------------------
module testbench;

  // Operation codes that the engine ignores, and the fourth state kind code
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  typedef struct {
    logic [2:0]                   op;
    logic [7:0]                   slot;
    logic [tmse_pkg::STATE_W-1:0] from_state;
    logic [tmse_pkg::SYM_W-1:0]   read_symbol;
    logic [tmse_pkg::STATE_W-1:0] next_state;
    logic [tmse_pkg::SYM_W-1:0]   write_symbol;
    logic                         move_right;
    logic [tmse_pkg::STATE_W-1:0] state_id;
    logic [1:0]                   state_kind;
    logic [tmse_pkg::TAPE_AW-1:0] tape_address;
    logic [tmse_pkg::SYM_W-1:0]   tape_symbol;
  } tm_item_t;

  typedef struct {
    logic [tmse_pkg::STATE_W-1:0] state;
    tmse_pkg::status_e            status;
    logic [tmse_pkg::STEP_W-1:0]  steps;
    logic [tmse_pkg::TAPE_AW-1:0] head;
    logic [tmse_pkg::SYM_W-1:0]   written;
  } tm_report_t;

  // Ports of the engine
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         operation_i = '0;
  logic [7:0]         slot_i = '0;
  logic [7:0]         from_state_i = '0;
  logic [7:0]         read_symbol_i = '0;
  logic [7:0]         next_state_i = '0;
  logic [7:0]         write_symbol_i = '0;
  logic               move_right_i = 1'b0;
  logic [7:0]         state_id_i = '0;
  logic [1:0]         state_kind_i = '0;
  logic [9:0]         tape_address_i = '0;
  logic [7:0]         tape_symbol_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         current_state_o;
  logic [2:0]         status_o;
  logic [15:0]        step_count_o;
  logic [9:0]         head_position_o;
  logic [7:0]         symbol_written_o;

  // Machine model: stores, registers and configuration shadow
  tmse_pkg::rule_t              rule_mem [tmse_pkg::TRANSITION_SLOTS];
  logic                         rule_ok  [tmse_pkg::TRANSITION_SLOTS];
  logic [1:0]                   kind_mem [tmse_pkg::STATE_COUNT];
  logic [tmse_pkg::SYM_W-1:0]   tape_mem [tmse_pkg::TAPE_CELLS];
  logic [tmse_pkg::STATE_W-1:0] tm_state = '0;
  logic [tmse_pkg::TAPE_AW-1:0] tm_head = '0;
  logic [tmse_pkg::STEP_W-1:0]  tm_steps = '0;
  tmse_pkg::status_e            tm_status = tmse_pkg::ST_RUN;
  logic [tmse_pkg::STATE_W-1:0] cfg_start = '0;
  logic [tmse_pkg::STEP_W-1:0]  cfg_max = tmse_pkg::MAX_STEPS_RESET;

  tm_item_t           item_q[$];
  tm_report_t         report_q[$];
  tm_item_t           cur_item;
  int                 n_items = 0;
  int                 n_results = 0;
  int                 n_errors = 0;
  int                 status_hits [8];
  int                 tx_gap = 0;
  bit                 tx_steady = 1'b0;
  int                 rx_stall = 0;
  bit                 rx_steady = 1'b0;
  logic               rx_hold = 1'b0;

  turing_machine_step_engine uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .slot_i           (slot_i),
    .from_state_i     (from_state_i),
    .read_symbol_i    (read_symbol_i),
    .next_state_i     (next_state_i),
    .write_symbol_i   (write_symbol_i),
    .move_right_i     (move_right_i),
    .state_id_i       (state_id_i),
    .state_kind_i     (state_kind_i),
    .tape_address_i   (tape_address_i),
    .tape_symbol_i    (tape_symbol_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .current_state_o  (current_state_o),
    .status_o         (status_o),
    .step_count_o     (step_count_o),
    .head_position_o  (head_position_o),
    .symbol_written_o (symbol_written_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one item to the machine and return the report it produces
  function automatic tm_report_t advance_machine(input tm_item_t it);
    tm_report_t res;
    logic [tmse_pkg::SYM_W-1:0] sym;
    logic [tmse_pkg::SYM_W-1:0] wrote;
    logic [1:0] kind;
    int hit;
    int i;
    wrote = '0;
    case (it.op)
      tmse_pkg::OP_LOAD: begin
        rule_ok[it.slot] = 1'b1;
        rule_mem[it.slot].from_state   = it.from_state;
        rule_mem[it.slot].read_symbol  = it.read_symbol;
        rule_mem[it.slot].next_state   = it.next_state;
        rule_mem[it.slot].write_symbol = it.write_symbol;
        rule_mem[it.slot].move_right   = it.move_right;
      end
      tmse_pkg::OP_KIND: kind_mem[it.state_id] = it.state_kind;
      tmse_pkg::OP_TAPE: tape_mem[it.tape_address] = it.tape_symbol;
      tmse_pkg::OP_RESTART: begin
        tm_state = cfg_start;
        tm_head = '0;
        tm_steps = '0;
        tm_status = tmse_pkg::ST_RUN;
      end
      tmse_pkg::OP_STEP: begin
        if (tm_status == tmse_pkg::ST_RUN) begin
          if (tm_steps >= cfg_max) begin
            tm_status = tmse_pkg::ST_QUIT;
          end else begin
            // Search slots in order for the first matching rule
            sym = tape_mem[tm_head];
            hit = -1;
            for (i = 0; i < tmse_pkg::TRANSITION_SLOTS; i++) begin
              if (hit < 0 && rule_ok[i] && rule_mem[i].from_state == tm_state &&
                  rule_mem[i].read_symbol == sym) begin
                hit = i;
              end
            end
            if (hit < 0) begin
              tm_status = tmse_pkg::ST_NOTRANS;
            end else begin
              wrote = rule_mem[hit].write_symbol;
              tape_mem[tm_head] = wrote;
              tm_state = rule_mem[hit].next_state;
              tm_steps = tm_steps + 1'b1;
              kind = kind_mem[tm_state];
              if (kind == tmse_pkg::KIND_ACCEPT) begin
                tm_status = tmse_pkg::ST_ACCEPT;
              end else if (kind == tmse_pkg::KIND_REJECT) begin
                tm_status = tmse_pkg::ST_REJECT;
              end else if (rule_mem[hit].move_right) begin
                if (tm_head == tmse_pkg::TAPE_CELLS - 1) tm_status = tmse_pkg::ST_OFFTAPE;
                else tm_head = tm_head + 1'b1;
              end else begin
                if (tm_head == 0) tm_status = tmse_pkg::ST_OFFTAPE;
                else tm_head = tm_head - 1'b1;
              end
              if (tm_status == tmse_pkg::ST_RUN && tm_steps >= cfg_max)
                tm_status = tmse_pkg::ST_QUIT;
            end
          end
        end
      end
      default: ;
    endcase
    res.state   = tm_state;
    res.status  = tm_status;
    res.steps   = tm_steps;
    res.head    = tm_head;
    res.written = wrote;
    return res;
  endfunction

  // Item builders: every field random, then the ones that matter set
  function automatic tm_item_t rand_item();
    tm_item_t it;
    it.op           = 3'($urandom_range(0, 7));
    it.slot         = 8'($urandom);
    it.from_state   = 8'($urandom);
    it.read_symbol  = 8'($urandom);
    it.next_state   = 8'($urandom);
    it.write_symbol = 8'($urandom);
    it.move_right   = 1'($urandom_range(0, 1));
    it.state_id     = 8'($urandom);
    it.state_kind   = 2'($urandom_range(0, 3));
    it.tape_address = 10'($urandom_range(0, tmse_pkg::TAPE_CELLS - 1));
    it.tape_symbol  = 8'($urandom);
    return it;
  endfunction

  function automatic tm_item_t mk_op(input logic [2:0] op);
    tm_item_t it;
    it = rand_item();
    it.op = op;
    return it;
  endfunction

  function automatic tm_item_t mk_load(input logic [7:0] slot, input logic [7:0] from_st,
                                       input logic [7:0] rd, input logic [7:0] nxt,
                                       input logic [7:0] wr, input logic right);
    tm_item_t it;
    it = mk_op(tmse_pkg::OP_LOAD);
    it.slot         = slot;
    it.from_state   = from_st;
    it.read_symbol  = rd;
    it.next_state   = nxt;
    it.write_symbol = wr;
    it.move_right   = right;
    return it;
  endfunction

  function automatic tm_item_t mk_kind(input logic [7:0] id, input logic [1:0] kind);
    tm_item_t it;
    it = mk_op(tmse_pkg::OP_KIND);
    it.state_id   = id;
    it.state_kind = kind;
    return it;
  endfunction

  function automatic tm_item_t mk_tape(input logic [9:0] addr, input logic [7:0] sym);
    tm_item_t it;
    it = mk_op(tmse_pkg::OP_TAPE);
    it.tape_address = addr;
    it.tape_symbol  = sym;
    return it;
  endfunction

  // Queue one short machine program with random content, or a burst of noise
  function automatic int queue_program();
    logic [7:0] st [4];
    logic [7:0] sy [3];
    int k;
    int cnt;
    logic [7:0] slot;
    cnt = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        item_q.push_back(rand_item());
        cnt++;
      end
      return cnt;
    end
    st[0] = cfg_start;
    for (k = 1; k < 4; k++) st[k] = 8'($urandom);
    for (k = 0; k < 3; k++) sy[k] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    // Rules mostly in low slots so searches stay short
    repeat ($urandom_range(2, 8)) begin
      slot = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      item_q.push_back(mk_load(slot, st[$urandom_range(0, 3)], sy[$urandom_range(0, 2)],
                               st[$urandom_range(0, 3)], sy[$urandom_range(0, 2)],
                               1'($urandom_range(0, 1))));
      cnt++;
    end
    repeat ($urandom_range(0, 2)) begin
      item_q.push_back(mk_kind(st[$urandom_range(1, 3)], 2'($urandom_range(0, 3))));
      cnt++;
    end
    if ($urandom_range(0, 7) == 0) begin
      item_q.push_back(mk_kind(st[0], tmse_pkg::KIND_NONE));
      cnt++;
    end
    repeat ($urandom_range(1, 6)) begin
      item_q.push_back(mk_tape(($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                             : 10'($urandom_range(0, 7)),
                               sy[$urandom_range(0, 2)]));
      cnt++;
    end
    // Now and then skip the restart and step on whatever run is left
    if ($urandom_range(0, 9) != 0) begin
      item_q.push_back(mk_op(tmse_pkg::OP_RESTART));
      cnt++;
    end
    repeat ($urandom_range(3, 25)) begin
      item_q.push_back(mk_op(tmse_pkg::OP_STEP));
      cnt++;
    end
    return cnt;
  endfunction

  task automatic write_cfg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tmse_pkg::CFG_START_STATE) cfg_start = val[7:0];
    else cfg_max = val;
  endtask

  // Hold until every queued item has gone in and every report has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (item_q.size() != 0 || in_valid_i || report_q.size() != 0);
  endtask

  // Driver: offer queued items, predict each one as it is accepted
  always @(posedge clk_i) begin : sender
    logic take;
    if (rst_ni) begin
      take = in_valid_i && (in_ready_o === 1'b1);
      if (take) begin
        report_q.push_back(advance_machine(cur_item));
        n_items++;
      end
      if (!in_valid_i || take) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (item_q.size() != 0) begin
          cur_item = item_q.pop_front();
          operation_i    <= cur_item.op;
          slot_i         <= cur_item.slot;
          from_state_i   <= cur_item.from_state;
          read_symbol_i  <= cur_item.read_symbol;
          next_state_i   <= cur_item.next_state;
          write_symbol_i <= cur_item.write_symbol;
          move_right_i   <= cur_item.move_right;
          state_id_i     <= cur_item.state_id;
          state_kind_i   <= cur_item.state_kind;
          tape_address_i <= cur_item.tape_address;
          tape_symbol_i  <= cur_item.tape_symbol;
          in_valid_i     <= 1'b1;
          if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
          tx_gap = tx_steady ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk_i) begin : receiver
    tm_report_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_ready_i) begin
        n_results++;
        if (report_q.size() == 0) begin
          flag_error($sformatf("result with none expected: state %0d status %0d",
                               current_state_o, status_o));
        end else begin
          want = report_q.pop_front();
          status_hits[want.status]++;
          if (current_state_o !== want.state)
            flag_error($sformatf("item result %0d current_state %0d, want %0d",
                                 n_results, current_state_o, want.state));
          if (status_o !== want.status)
            flag_error($sformatf("item result %0d status %0d, want %0d",
                                 n_results, status_o, want.status));
          if (step_count_o !== want.steps)
            flag_error($sformatf("item result %0d step_count %0d, want %0d",
                                 n_results, step_count_o, want.steps));
          if (head_position_o !== want.head)
            flag_error($sformatf("item result %0d head_position %0d, want %0d",
                                 n_results, head_position_o, want.head));
          if (symbol_written_o !== want.written)
            flag_error($sformatf("item result %0d symbol_written %0d, want %0d",
                                 n_results, symbol_written_o, want.written));
        end
      end
      // Random back-pressure, with stretches of none
      if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
      if (rx_stall > 0) rx_stall--;
      else if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = idle_len();
      out_ready_i <= !rx_hold && (rx_stall == 0);
    end
  end

  // Long receiver hold-offs while the sender keeps offering items
  initial begin : rx_hold_off
    wait (n_results >= 60);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
    wait (n_results >= 1200);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Stimulus
  initial begin : stimulus
    int i;
    int ph;
    int cnt;
    int budget;
    logic [7:0] st;
    logic [15:0] lim;
    for (i = 0; i < tmse_pkg::TRANSITION_SLOTS; i++) rule_ok[i] = 1'b0;
    for (i = 0; i < tmse_pkg::STATE_COUNT; i++) kind_mem[i] = tmse_pkg::KIND_NONE;
    for (i = 0; i < tmse_pkg::TAPE_CELLS; i++) tape_mem[i] = '0;
    for (i = 0; i < 8; i++) status_hits[i] = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_cfg(tmse_pkg::CFG_START_STATE, 16'd0);
    write_cfg(tmse_pkg::CFG_MAX_STEPS, tmse_pkg::MAX_STEPS_RESET);
    @(negedge clk_i);

    // Directed: empty rule set, halted run, slot priority, kinds, both tape ends
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    item_q.push_back(mk_load(8'd255, 8'd0, 8'd0, 8'hFF, 8'hFF, 1'b0));
    item_q.push_back(mk_load(8'd0, 8'd0, 8'd0, 8'd1, 8'hAA, 1'b1));
    item_q.push_back(mk_op(tmse_pkg::OP_RESTART));
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    item_q.push_back(mk_tape(10'd1023, 8'hFF));
    item_q.push_back(mk_tape(10'd0, 8'hAA));
    item_q.push_back(mk_kind(8'd255, tmse_pkg::KIND_ACCEPT));
    item_q.push_back(mk_kind(8'd254, tmse_pkg::KIND_REJECT));
    item_q.push_back(mk_kind(8'h80, KIND_SPARE));
    item_q.push_back(mk_kind(8'd0, tmse_pkg::KIND_NONE));
    for (i = int'(OP_SPARE_LO); i <= int'(OP_SPARE_HI); i++) item_q.push_back(mk_op(3'(i)));
    item_q.push_back(mk_load(8'd1, 8'd1, 8'd0, 8'h80, 8'h55, 1'b0));
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    // Move left from cell 0 runs off the tape
    item_q.push_back(mk_load(8'd2, 8'h80, 8'hAA, 8'h80, 8'h11, 1'b0));
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    // Accept, then reject
    item_q.push_back(mk_op(tmse_pkg::OP_RESTART));
    item_q.push_back(mk_load(8'd3, 8'd0, 8'h11, 8'hFF, 8'h22, 1'b1));
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    item_q.push_back(mk_load(8'd4, 8'd0, 8'h22, 8'hFE, 8'h00, 1'b0));
    item_q.push_back(mk_op(tmse_pkg::OP_RESTART));
    item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    wait_drained();

    // Walk the whole tape to the right until the head runs off the far end
    write_cfg(tmse_pkg::CFG_START_STATE, 16'd7);
    write_cfg(tmse_pkg::CFG_MAX_STEPS, 16'hFFFF);
    @(negedge clk_i);
    item_q.push_back(mk_tape(10'd0, 8'd0));
    item_q.push_back(mk_tape(10'd1, 8'd0));
    item_q.push_back(mk_load(8'd5, 8'd7, 8'd0, 8'd7, 8'd0, 1'b1));
    item_q.push_back(mk_load(8'd6, 8'd7, 8'hFF, 8'd7, 8'hA5, 1'b1));
    item_q.push_back(mk_op(tmse_pkg::OP_RESTART));
    repeat (tmse_pkg::TAPE_CELLS + 1) item_q.push_back(mk_op(tmse_pkg::OP_STEP));
    wait_drained();

    // Random programs under several start states and step limits
    for (ph = 0; ph < 6; ph++) begin
      st = 8'($urandom);
      budget = 55;
      case (ph)
        0: begin
          st = 8'd0;
          lim = 16'd0;
          budget = 30;
        end
        1: begin
          st = 8'd255;
          lim = 16'hFFFF;
        end
        2: lim = 16'd1;
        3: lim = 16'($urandom_range(2, 40));
        4: lim = tmse_pkg::MAX_STEPS_RESET;
        default: lim = 16'($urandom_range(0, 65535));
      endcase
      write_cfg(tmse_pkg::CFG_START_STATE, {8'd0, st});
      write_cfg(tmse_pkg::CFG_MAX_STEPS, lim);
      @(negedge clk_i);
      cnt = 0;
      while (cnt < budget) cnt += queue_program();
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    if (report_q.size() != 0) flag_error($sformatf("%0d results never came", report_q.size()));
    $display("run covered %0d items and %0d results, %0d mismatches", n_items, n_results,
             n_errors);
    $display("results by status: run %0d accept %0d reject %0d quit %0d no-rule %0d off-tape %0d",
             status_hits[tmse_pkg::ST_RUN], status_hits[tmse_pkg::ST_ACCEPT],
             status_hits[tmse_pkg::ST_REJECT], status_hits[tmse_pkg::ST_QUIT],
             status_hits[tmse_pkg::ST_NOTRANS], status_hits[tmse_pkg::ST_OFFTAPE]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Time limit
  initial begin : watchdog
    #8_000_000;
    $display("timeout after %0d items and %0d results", n_items, n_results);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
